// ===== rtl/core/byte_ring_fifo_with_tentative_pointers_core_defines.svh =====
// Assertion macros for the byte ring FIFO core.
// Used by the top level only; needs nothing else.
`ifndef BYTE_RING_FIFO_WITH_TENTATIVE_POINTERS_CORE_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_TENTATIVE_POINTERS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRFTP_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error("brftp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BRFTP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error("brftp: next-cycle check failed");

`endif

// ===== rtl/core/brftp_pkg.sv =====
// Package for the byte ring FIFO core: sizes, request codes, FSM states
// and the byte store command struct. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package brftp_pkg;

	localparam int PTR_W  = 10;            // ring index width
	localparam int DEPTH  = 1 << PTR_W;    // ring entries
	localparam int DATA_W = 8;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [DATA_W-1:0] byte_t;

	typedef enum logic [3:0] {
		REQ_WRITE     = 4'd0,
		REQ_READ      = 4'd1,
		REQ_ADV_WR    = 4'd2,
		REQ_ADV_RD    = 4'd3,
		REQ_SET_RD    = 4'd4,
		REQ_BEGIN_WR  = 4'd5,
		REQ_END_WR    = 4'd6,
		REQ_BEGIN_RD  = 4'd7,
		REQ_END_RD    = 4'd8,
		REQ_RESET     = 4'd9
	} req_code_t;

	typedef enum logic {
		ST_IDLE,
		ST_FINISH
	} fsm_state_t;

	typedef struct packed {
		logic  we;
		ptr_t  waddr;
		byte_t wdata;
		logic  re;
		ptr_t  raddr;
	} mem_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/brftp_if.sv =====
// Request and response channel interfaces of the byte ring FIFO core.
// Valid/ready handshake; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface brftp_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  req_type;
	logic [7:0]  data_byte;
	logic [15:0] amount;
	logic [15:0] new_read_index;
	logic        commit;

	modport source (output valid, input ready,
		output req_type, data_byte, amount, new_read_index, commit);
	modport sink (input valid, output ready,
		input req_type, data_byte, amount, new_read_index, commit);
endinterface

interface brftp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       read_valid;
	logic       is_empty;
	logic       is_full;
	logic [9:0] fill_count;
	logic [9:0] read_position;
	logic [9:0] write_position;

	modport source (output valid, input ready,
		output read_data, read_valid, is_empty, is_full, fill_count,
		read_position, write_position);
	modport sink (input valid, output ready,
		input read_data, read_valid, is_empty, is_full, fill_count,
		read_position, write_position);
endinterface

`default_nettype wire

// ===== rtl/core/brftp_store.sv =====
// Byte store of the ring: one write port, one read port, registered read.
// Depends on brftp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brftp_store (
	input  wire logic              clk,
	input  wire brftp_pkg::mem_cmd_t cmd,
	output brftp_pkg::byte_t       rdata
);
	import brftp_pkg::*;

	byte_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[cmd.waddr] <= cmd.wdata;
		end
		// hold the last byte read until the next read
		if (cmd.re) begin
			rdata <= mem_q[cmd.raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_fifo_with_tentative_pointers_core.sv =====
// Top level of the byte ring FIFO with tentative (shadow) pointers.
// Depends on brftp_pkg, brftp_if, brftp_store and the defines header.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   req_type, data_byte, amount, new_read_index, commit
//  rsp      out  valid/ready   read_data, read_valid, is_empty, is_full,
//                              fill_count, read_position, write_position
//
// The accept cycle updates the pointers and issues the byte store access; the
// finish state then collects the registered store read and loads the response
// register. Pointers and flags clear at once on reset; the byte store is not
// cleared. A word can be accepted while a response waits; the block then holds
// in its finish cycle until the response register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_ring_fifo_with_tentative_pointers_core_defines.svh"

module byte_ring_fifo_with_tentative_pointers_core (
	input wire logic   clk,
	input wire logic   arst_n,
	brftp_req_if.sink  req,
	brftp_rsp_if.source rsp
);
	import brftp_pkg::*;

	fsm_state_t state_q, state_d;

	ptr_t wp_q, rp_q, swp_q, srp_q;
	ptr_t wp_d, rp_d, swp_d, srp_d;
	logic tw_q, tr_q, tw_d, tr_d;

	logic     req_acc;
	logic     load_out;
	logic     read_hit;
	logic     read_hit_s1;
	ptr_t     rd_ptr;
	ptr_t     fill;
	mem_cmd_t mem_cmd;
	byte_t    mem_rdata;
	req_code_t code;

	logic       rsp_valid_q;
	byte_t      rsp_data_q;
	logic       rsp_rvalid_q;
	logic       rsp_empty_q;
	logic       rsp_full_q;
	logic [9:0] rsp_fill_q;
	logic [9:0] rsp_rpos_q;
	logic [9:0] rsp_wpos_q;

	assign code    = req_code_t'(req.req_type);
	assign req_acc = req.valid && req.ready;
	assign rd_ptr  = tr_q ? srp_q : rp_q;

	// next pointer values and store access for the accepted word
	always_comb begin
		wp_d     = wp_q;
		rp_d     = rp_q;
		swp_d    = swp_q;
		srp_d    = srp_q;
		tw_d     = tw_q;
		tr_d     = tr_q;
		read_hit = 1'b0;
		mem_cmd  = '0;
		case (code)
			REQ_WRITE: begin
				mem_cmd.we    = 1'b1;
				mem_cmd.waddr = tw_q ? swp_q : wp_q;
				mem_cmd.wdata = req.data_byte;
				if (tw_q) begin
					swp_d = swp_q + ptr_t'(1);
				end else begin
					wp_d = wp_q + ptr_t'(1);
				end
			end
			REQ_READ: begin
				// empty test against the active read pointer
				if (wp_q != rd_ptr) begin
					read_hit      = 1'b1;
					mem_cmd.re    = 1'b1;
					mem_cmd.raddr = rd_ptr;
					if (tr_q) begin
						srp_d = srp_q + ptr_t'(1);
					end else begin
						rp_d = rp_q + ptr_t'(1);
					end
				end
			end
			REQ_ADV_WR: wp_d = wp_q + req.amount[PTR_W-1:0];
			REQ_ADV_RD: rp_d = rp_q + req.amount[PTR_W-1:0];
			REQ_SET_RD: rp_d = req.new_read_index[PTR_W-1:0];
			REQ_BEGIN_WR: begin
				swp_d = wp_q;
				tw_d  = 1'b1;
			end
			REQ_END_WR: begin
				tw_d = 1'b0;
				if (req.commit) begin
					wp_d = swp_q;
				end
			end
			REQ_BEGIN_RD: begin
				srp_d = rp_q;
				tr_d  = 1'b1;
			end
			REQ_END_RD: begin
				tr_d = 1'b0;
				if (req.commit) begin
					rp_d = srp_q;
				end
			end
			REQ_RESET: begin
				wp_d = '0;
				rp_d = '0;
				tw_d = 1'b0;
				tr_d = 1'b0;
			end
			default: ;
		endcase
		if (!req_acc) begin
			mem_cmd = '0;
		end
	end

	brftp_store u_store (
		.clk   (clk),
		.cmd   (mem_cmd),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the FSM
	always_comb begin
		req.ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_FINISH: load_out  = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			swp_q   <= '0;
			srp_q   <= '0;
			tw_q    <= 1'b0;
			tr_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_acc) begin
				wp_q  <= wp_d;
				rp_q  <= rp_d;
				swp_q <= swp_d;
				srp_q <= srp_d;
				tw_q  <= tw_d;
				tr_q  <= tr_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			read_hit_s1 <= read_hit;
		end
	end

	// pointers do not move while finishing, so status comes straight from them
	assign fill = wp_q - rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_data_q   <= read_hit_s1 ? mem_rdata : '0;
			rsp_rvalid_q <= read_hit_s1;
			rsp_empty_q  <= (wp_q == rp_q);
			rsp_full_q   <= (fill == ptr_t'(DEPTH - 1));
			rsp_fill_q   <= fill;
			rsp_rpos_q   <= rp_q;
			rsp_wpos_q   <= wp_q;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_data      = rsp_data_q;
	assign rsp.read_valid     = rsp_rvalid_q;
	assign rsp.is_empty       = rsp_empty_q;
	assign rsp.is_full        = rsp_full_q;
	assign rsp.fill_count     = rsp_fill_q;
	assign rsp.read_position  = rsp_rpos_q;
	assign rsp.write_position = rsp_wpos_q;

	`BRFTP_ASSERT_NEXT(a_acc_finish, clk, arst_n, req_acc, state_q == ST_FINISH && !req.ready)
	`BRFTP_ASSERT_NEXT(a_load_valid, clk, arst_n, load_out, rsp.valid)
	`BRFTP_ASSERT_IMPL(a_miss_zero, clk, arst_n, rsp.valid && !rsp.read_valid, rsp.read_data == 8'd0)
	`BRFTP_ASSERT_IMPL(a_empty_fill, clk, arst_n, rsp.valid, rsp.is_empty == (rsp.fill_count == 10'd0))

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the byte ring FIFO core with tentative pointers.
// Drives request words against a predictor and checks every response word;
// depends on brftp_pkg, brftp_if and the core top level.
`timescale 1ns / 1ps

module tb;
	import brftp_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_WORDS   = 155;
	localparam int PRINT_CAP     = 40;
	localparam int DRAIN_CYCLES  = 10;

	typedef struct packed {
		logic [3:0]  code;
		byte_t       data;
		logic [15:0] amount;
		logic [15:0] new_idx;
		logic        commit;
	} req_word_t;

	typedef struct packed {
		byte_t data;
		logic  rvalid;
		logic  empty;
		logic  full;
		ptr_t  fill;
		ptr_t  rpos;
		ptr_t  wpos;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	brftp_req_if req_ch ();
	brftp_rsp_if rsp_ch ();

	byte_ring_fifo_with_tentative_pointers_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Bus drive, known from time zero
	logic      drv_valid = 1'b0;
	req_word_t drv_word = '0;
	logic      sink_ready = 1'b0;

	assign req_ch.valid          = drv_valid;
	assign req_ch.req_type       = drv_word.code;
	assign req_ch.data_byte      = drv_word.data;
	assign req_ch.amount         = drv_word.amount;
	assign req_ch.new_read_index = drv_word.new_idx;
	assign req_ch.commit         = drv_word.commit;
	assign rsp_ch.ready          = sink_ready;

	req_word_t pending_reqs[$];
	rsp_word_t expected_status[$];

	int send_idle_pct = 15;
	int recv_idle_pct = 87;
	int mismatches = 0;
	int words_sent = 0;
	int bytes_returned = 0;
	int full_reports = 0;
	int cycles = 0;

	// Predicted ring state
	byte_t ring_bytes [DEPTH];
	bit    entry_written [DEPTH];
	ptr_t  wr_ptr = '0;
	ptr_t  rd_ptr = '0;
	ptr_t  sh_wr = '0;
	ptr_t  sh_rd = '0;
	logic  tw_active = 1'b0;
	logic  tr_active = 1'b0;

	function automatic void predict_status(req_word_t w);
		rsp_word_t r;
		ptr_t      rd_src;
		ptr_t      fill;
		r = '0;
		rd_src = tr_active ? sh_rd : rd_ptr;
		case (w.code)
			REQ_WRITE: begin
				if (tw_active) begin
					ring_bytes[sh_wr] = w.data;
					entry_written[sh_wr] = 1'b1;
					sh_wr = sh_wr + 1'b1;
				end else begin
					ring_bytes[wr_ptr] = w.data;
					entry_written[wr_ptr] = 1'b1;
					wr_ptr = wr_ptr + 1'b1;
				end
			end
			REQ_READ: begin
				// empty test against the active read pointer
				if (wr_ptr != rd_src) begin
					r.data = ring_bytes[rd_src];
					r.rvalid = 1'b1;
					if (tr_active)
						sh_rd = sh_rd + 1'b1;
					else
						rd_ptr = rd_ptr + 1'b1;
				end
			end
			REQ_ADV_WR: wr_ptr = wr_ptr + w.amount[PTR_W-1:0];
			REQ_ADV_RD: rd_ptr = rd_ptr + w.amount[PTR_W-1:0];
			REQ_SET_RD: rd_ptr = w.new_idx[PTR_W-1:0];
			REQ_BEGIN_WR: begin
				sh_wr = wr_ptr;
				tw_active = 1'b1;
			end
			REQ_END_WR: begin
				tw_active = 1'b0;
				if (w.commit)
					wr_ptr = sh_wr;
			end
			REQ_BEGIN_RD: begin
				sh_rd = rd_ptr;
				tr_active = 1'b1;
			end
			REQ_END_RD: begin
				tr_active = 1'b0;
				if (w.commit)
					rd_ptr = sh_rd;
			end
			REQ_RESET: begin
				wr_ptr = '0;
				rd_ptr = '0;
				tw_active = 1'b0;
				tr_active = 1'b0;
			end
			default: ;
		endcase
		fill = wr_ptr - rd_ptr;
		r.empty = (wr_ptr == rd_ptr);
		r.full = (fill == ptr_t'(DEPTH - 1));
		r.fill = fill;
		r.rpos = rd_ptr;
		r.wpos = wr_ptr;
		if (r.rvalid)
			bytes_returned++;
		if (r.full)
			full_reports++;
		words_sent++;
		expected_status.push_back(r);
	endfunction

	// Swap a read that would land on a never-written byte for a pointer reset;
	// the predictor is up to date whenever a new word is offered
	function automatic req_word_t guard_read(req_word_t w);
		req_word_t g;
		ptr_t      rd_src;
		g = w;
		rd_src = tr_active ? sh_rd : rd_ptr;
		if (w.code == REQ_READ && wr_ptr != rd_src && !entry_written[rd_src])
			g.code = REQ_RESET;
		return g;
	endfunction

	task automatic report_mismatch(string what, int got_v, int want_v);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got_v, want_v);
	endtask

	task automatic check_status();
		rsp_word_t want;
		if (expected_status.size() == 0) begin
			report_mismatch("response with none expected", 1, 0);
		end else begin
			want = expected_status.pop_front();
			if (rsp_ch.read_data !== want.data)
				report_mismatch("read_data", rsp_ch.read_data, want.data);
			if (rsp_ch.read_valid !== want.rvalid)
				report_mismatch("read_valid", rsp_ch.read_valid, want.rvalid);
			if (rsp_ch.is_empty !== want.empty)
				report_mismatch("is_empty", rsp_ch.is_empty, want.empty);
			if (rsp_ch.is_full !== want.full)
				report_mismatch("is_full", rsp_ch.is_full, want.full);
			if (rsp_ch.fill_count !== want.fill)
				report_mismatch("fill_count", rsp_ch.fill_count, want.fill);
			if (rsp_ch.read_position !== want.rpos)
				report_mismatch("read_position", rsp_ch.read_position, want.rpos);
			if (rsp_ch.write_position !== want.wpos)
				report_mismatch("write_position", rsp_ch.write_position, want.wpos);
		end
	endtask

	// Driver: predict on acceptance, then offer the next word or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_word <= '0;
		end else begin
			if (drv_valid && req_ch.ready)
				predict_status(drv_word);
			if (!drv_valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_word <= guard_read(pending_reqs.pop_front());
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted response word, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && sink_ready)
				check_status();
			sink_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	function automatic req_word_t rand_word(logic [3:0] code);
		req_word_t w;
		w.code = code;
		w.data = byte_t'($urandom);
		w.amount = 16'($urandom);
		w.new_idx = 16'($urandom);
		w.commit = 1'($urandom);
		return w;
	endfunction

	task automatic queue_word(logic [3:0] code, int data_v, int amount_v, int idx_v,
			logic commit_v);
		req_word_t w;
		w = rand_word(code);
		if (data_v >= 0)
			w.data = byte_t'(data_v);
		if (amount_v >= 0)
			w.amount = 16'(amount_v);
		if (idx_v >= 0)
			w.new_idx = 16'(idx_v);
		w.commit = commit_v;
		pending_reqs.push_back(w);
	endtask

	// Hold the sender until every expected response has come back
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || drv_valid || expected_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_random_phase();
		int n;
		int k;
		int kind;
		n = 0;
		while (n < PHASE_WORDS) begin
			kind = $urandom_range(9);
			if (kind <= 2) begin
				k = $urandom_range(1, 8);
				repeat (k) pending_reqs.push_back(rand_word(REQ_WRITE));
				n += k;
				k = $urandom_range(1, 10);
				repeat (k) pending_reqs.push_back(rand_word(REQ_READ));
				n += k;
			end else if (kind <= 4) begin
				k = $urandom_range(0, 6);
				pending_reqs.push_back(rand_word(REQ_BEGIN_WR));
				repeat (k) pending_reqs.push_back(rand_word(REQ_WRITE));
				pending_reqs.push_back(rand_word(REQ_END_WR));
				n += k + 2;
			end else if (kind <= 6) begin
				k = $urandom_range(0, 6);
				pending_reqs.push_back(rand_word(REQ_BEGIN_RD));
				repeat (k) pending_reqs.push_back(rand_word(REQ_READ));
				pending_reqs.push_back(rand_word(REQ_END_RD));
				n += k + 2;
			end else begin
				// noise: any code, unused ones too
				pending_reqs.push_back(rand_word(4'($urandom_range(15))));
				n++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words
		queue_word(REQ_READ, -1, -1, -1, 1'b0);
		queue_word(REQ_WRITE, 8'h00, -1, -1, 1'b0);
		queue_word(REQ_WRITE, 8'hFF, -1, -1, 1'b0);
		queue_word(REQ_READ, -1, -1, -1, 1'b0);
		queue_word(REQ_READ, -1, -1, -1, 1'b0);
		queue_word(REQ_READ, -1, -1, -1, 1'b0);
		queue_word(REQ_ADV_WR, -1, 16'hFFFF, -1, 1'b0);
		queue_word(REQ_READ, -1, -1, -1, 1'b0);
		queue_word(REQ_ADV_RD, -1, 0, -1, 1'b0);
		queue_word(REQ_ADV_RD, -1, 16'h8001, -1, 1'b0);
		queue_word(REQ_SET_RD, -1, -1, 16'hFFFF, 1'b0);
		queue_word(REQ_SET_RD, -1, -1, 0, 1'b0);
		queue_word(REQ_RESET, -1, -1, -1, 1'b0);
		queue_word(REQ_BEGIN_WR, -1, -1, -1, 1'b0);
		queue_word(REQ_WRITE, 8'hA5, -1, -1, 1'b0);
		queue_word(REQ_BEGIN_WR, -1, -1, -1, 1'b0);
		queue_word(REQ_WRITE, 8'h5A, -1, -1, 1'b0);
		queue_word(REQ_END_WR, -1, -1, -1, 1'b0);
		queue_word(REQ_BEGIN_WR, -1, -1, -1, 1'b0);
		queue_word(REQ_WRITE, 8'h3C, -1, -1, 1'b0);
		queue_word(REQ_WRITE, 8'hC3, -1, -1, 1'b0);
		queue_word(REQ_END_WR, -1, -1, -1, 1'b1);
		queue_word(REQ_BEGIN_RD, -1, -1, -1, 1'b0);
		queue_word(REQ_READ, -1, -1, -1, 1'b0);
		queue_word(REQ_READ, -1, -1, -1, 1'b0);
		queue_word(REQ_READ, -1, -1, -1, 1'b0);
		queue_word(REQ_END_RD, -1, -1, -1, 1'b0);
		queue_word(REQ_BEGIN_RD, -1, -1, -1, 1'b0);
		queue_word(REQ_READ, -1, -1, -1, 1'b0);
		queue_word(REQ_END_RD, -1, -1, -1, 1'b1);
		// end with no transaction open: stale shadow is still copied
		queue_word(REQ_END_WR, -1, -1, -1, 1'b1);
		queue_word(REQ_END_RD, -1, -1, -1, 1'b1);
		queue_word(REQ_BEGIN_WR, -1, -1, -1, 1'b0);
		queue_word(REQ_RESET, -1, -1, -1, 1'b0);
		queue_word(4'd10, -1, -1, -1, 1'b0);
		queue_word(4'd15, -1, -1, -1, 1'b1);

		queue_random_phase();
		wait_drained();

		@(negedge clk);
		send_idle_pct = 87;
		recv_idle_pct = 15;
		queue_random_phase();
		wait_drained();

		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_phase();
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d request words checked, %0d bytes returned by reads, full seen %0d times",
			words_sent, bytes_returned, full_reports);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0 && expected_status.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
